[design/lkvc_pkg.sv]
// lkvc_pkg: shared types and constants for the lru key-value cache
// used by the channel interfaces, the cell row, the controller and the top level
package lkvc_pkg;

   localparam int unsigned CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_GET  = 2'd0,
      OP_PUT  = 2'd1,
      OP_DEL  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   // per-cycle command broadcast from the controller to every cell
   typedef struct packed {
      logic compare;
      logic touch;
      logic remove;
      logic insert;
      logic evict;
   } cell_cmd_type;

endpackage

[design/lkvc_ifs.sv]
// lkvc channel interfaces: request, response and capacity write channels
// depends on lkvc_pkg for the capacity width
interface lkvc_req_if #(
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 64
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            op;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lkvc_rsp_if #(
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 64
);
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [VALUE_BITS-1:0] read_value;
   logic                  evicted;
   logic [KEY_BITS-1:0]   evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

interface lkvc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lkvc_pkg::CAP_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/lkvc_cell.sv]
// lkvc_cell: one slot of the recency-ordered entry row
// depends on lkvc_pkg; position in the row is the recency rank (first is most recent)
module lkvc_cell #(
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lkvc_pkg::cell_cmd_type     cmd,
   input  logic [KEY_BITS-1:0]        cmp_key,
   // neighbor toward the head (more recent)
   input  logic                       prev_valid,
   input  logic [KEY_BITS-1:0]        prev_key,
   input  logic [VALUE_BITS-1:0]      prev_value,
   // neighbor toward the tail (less recent)
   input  logic                       next_valid,
   input  logic [KEY_BITS-1:0]        next_key,
   input  logic [VALUE_BITS-1:0]      next_value,
   // chains running from tail to head
   input  logic                       after_in,
   output logic                       after_out,
   input  logic [VALUE_BITS-1:0]      rd_in,
   output logic [VALUE_BITS-1:0]      rd_out,
   input  logic [KEY_BITS-1:0]        lk_in,
   output logic [KEY_BITS-1:0]        lk_out,
   // own contents
   output logic                       valid,
   output logic [KEY_BITS-1:0]        key,
   output logic [VALUE_BITS-1:0]      value
);

   logic                  valid_ff, valid_in;
   logic                  match_ff, match_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      match_in = match_ff;
      if (cmd.compare) begin
         match_in = valid_ff && (key_ff == cmp_key);
      end
      if (cmd.touch && (match_ff || after_in)) begin
         // hit at or behind this cell: everything ahead of it moves back one
         valid_in = prev_valid;
         key_in   = prev_key;
         value_in = prev_value;
      end else if (cmd.remove && !after_in) begin
         // at or behind the removed item: close the gap
         valid_in = next_valid;
         key_in   = next_key;
         value_in = next_value;
      end else if (cmd.insert) begin
         // on eviction the last live item falls off as the row shifts
         valid_in = prev_valid && (!cmd.evict || valid_ff);
         key_in   = prev_key;
         value_in = prev_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign after_out = match_ff || after_in;
   assign rd_out    = rd_in | (match_ff ? value_ff : '0);
   assign lk_out    = lk_in | ((valid_ff && !next_valid) ? key_ff : '0);

   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;

endmodule

[design/lkvc_ctrl.sv]
// lkvc_ctrl: request sequencing, live count, capacity register and response register
// depends on lkvc_pkg and the lkvc channel interfaces
module lkvc_ctrl #(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   lkvc_req_if.sink               req,
   lkvc_rsp_if.source             rsp,
   lkvc_csr_if.sink               csr,
   output lkvc_pkg::cell_cmd_type cmd,
   output logic [KEY_BITS-1:0]    cmp_key,
   output logic [KEY_BITS-1:0]    head_key,
   output logic [VALUE_BITS-1:0]  head_value,
   input  logic                   row_hit,
   input  logic [VALUE_BITS-1:0]  row_value,
   input  logic [KEY_BITS-1:0]    row_last_key
);

   localparam int unsigned CNT_BITS = $clog2(ENTRIES + 1);
   localparam int unsigned CMP_BITS =
      (CNT_BITS > lkvc_pkg::CAP_BITS) ? CNT_BITS : lkvc_pkg::CAP_BITS;

   lkvc_pkg::state_type state_ff, state_in;
   lkvc_pkg::op_type    op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CNT_BITS-1:0]   live_count_ff, live_count_in;
   logic [lkvc_pkg::CAP_BITS-1:0] cap_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_evicted_ff;
   logic [KEY_BITS-1:0]   rsp_evicted_key_ff;

   logic accept, fire, full;
   logic is_get, is_put, is_del;
   logic [CMP_BITS-1:0] cap_eff;

   assign accept = req.valid && req.ready;
   assign fire   = (state_ff == lkvc_pkg::ST_UPDATE) && (!rsp_valid_ff || rsp.ready);

   assign is_get = (op_ff == lkvc_pkg::OP_GET);
   assign is_put = (op_ff == lkvc_pkg::OP_PUT);
   assign is_del = (op_ff == lkvc_pkg::OP_DEL);

   // zero capacity acts as one; above the pool the full row decides
   assign cap_eff = (cap_ff == '0) ? CMP_BITS'(1) : CMP_BITS'(cap_ff);
   assign full    = (live_count_ff == CNT_BITS'(ENTRIES)) ||
                    (CMP_BITS'(live_count_ff) >= cap_eff);

   always_comb begin
      cmd.compare = accept;
      cmd.touch   = fire && row_hit && (is_get || is_put);
      cmd.remove  = fire && row_hit && is_del;
      cmd.insert  = fire && !row_hit && is_put;
      cmd.evict   = fire && !row_hit && is_put && full;
   end

   assign cmp_key    = req.key;
   assign head_key   = key_ff;
   assign head_value = is_put ? value_ff : row_value;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (accept) state_in = lkvc_pkg::ST_UPDATE;
         end
         lkvc_pkg::ST_UPDATE: begin
            if (fire) state_in = lkvc_pkg::ST_IDLE;
         end
         default: state_in = lkvc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      live_count_in = live_count_ff;
      if (cmd.insert && !cmd.evict) begin
         live_count_in = live_count_ff + CNT_BITS'(1);
      end else if (cmd.remove) begin
         live_count_in = live_count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lkvc_pkg::ST_IDLE;
         live_count_ff <= '0;
         cap_ff        <= lkvc_pkg::CAP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr.valid) begin
            cap_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= lkvc_pkg::op_type'(req.op);
         key_ff   <= req.key;
         value_ff <= req.value;
      end
      if (fire) begin
         rsp_hit_ff         <= row_hit && (op_ff != lkvc_pkg::OP_NONE);
         rsp_value_ff       <= (is_get && row_hit) ? row_value : '0;
         rsp_evicted_ff     <= cmd.evict;
         rsp_evicted_key_ff <= cmd.evict ? row_last_key : '0;
      end
   end

   assign req.ready       = (state_ff == lkvc_pkg::ST_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = rsp_hit_ff;
   assign rsp.read_value  = rsp_value_ff;
   assign rsp.evicted     = rsp_evicted_ff;
   assign rsp.evicted_key = rsp_evicted_key_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= CNT_BITS'(ENTRIES))
      else $error("live count above pool size");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.touch, cmd.remove, cmd.insert}))
      else $error("more than one row command at once");

   a_evict_keeps_count: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |=> $stable(live_count_ff))
      else $error("eviction with insert changed the live count");

   a_accept_then_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == lkvc_pkg::ST_UPDATE))
      else $error("accepted item did not enter update");

   a_evict_not_hit: assert property (@(posedge clock) disable iff (reset)
      fire |=> !(rsp_evicted_ff && rsp_hit_ff))
      else $error("response reports both hit and eviction");
`endif

endmodule

[design/lru_key_value_cache.sv]
// lru_key_value_cache: top level, a row of recency-ordered cells plus controller
// the key compare runs in the accept cycle and the row shift in the update state;
//   the response is registered as the row shifts
// items do not overlap: the next accept waits until the last item leaves update;
//   a response left waiting holds the item in update and blocks the next accept
// reset: synchronous active high; empties the row, clears the live count,
//   sets capacity to 16 and drops any pending response
module lru_key_value_cache #(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   lkvc_req_if.sink   req,
   lkvc_rsp_if.source rsp,
   lkvc_csr_if.sink   csr
);

   lkvc_pkg::cell_cmd_type cmd;
   logic [KEY_BITS-1:0]    cmp_key;
   logic [KEY_BITS-1:0]    head_key;
   logic [VALUE_BITS-1:0]  head_value;

   // slot 0 is the incoming head entry, slots 1..ENTRIES the cells, last slot is empty
   logic                  s_valid [ENTRIES+2];
   logic [KEY_BITS-1:0]   s_key   [ENTRIES+2];
   logic [VALUE_BITS-1:0] s_value [ENTRIES+2];

   logic                  after [ENTRIES+1];
   logic [VALUE_BITS-1:0] rd    [ENTRIES+1];
   logic [KEY_BITS-1:0]   lk    [ENTRIES+1];

   assign s_valid[0] = 1'b1;
   assign s_key[0]   = head_key;
   assign s_value[0] = head_value;

   assign s_valid[ENTRIES+1] = 1'b0;
   assign s_key[ENTRIES+1]   = '0;
   assign s_value[ENTRIES+1] = '0;

   assign after[ENTRIES] = 1'b0;
   assign rd[ENTRIES]    = '0;
   assign lk[ENTRIES]    = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cmp_key    (cmp_key),
         .prev_valid (s_valid[i]),
         .prev_key   (s_key[i]),
         .prev_value (s_value[i]),
         .next_valid (s_valid[i+2]),
         .next_key   (s_key[i+2]),
         .next_value (s_value[i+2]),
         .after_in   (after[i+1]),
         .after_out  (after[i]),
         .rd_in      (rd[i+1]),
         .rd_out     (rd[i]),
         .lk_in      (lk[i+1]),
         .lk_out     (lk[i]),
         .valid      (s_valid[i+1]),
         .key        (s_key[i+1]),
         .value      (s_value[i+1])
      );
   end

   lkvc_ctrl #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr          (csr),
      .cmd          (cmd),
      .cmp_key      (cmp_key),
      .head_key     (head_key),
      .head_value   (head_value),
      .row_hit      (after[0]),
      .row_value    (rd[0]),
      .row_last_key (lk[0])
   );

endmodule

[bench/lru_key_value_cache_tb.sv]
`timescale 1ns / 100ps
// lru_key_value_cache_tb: self-checking bench for the lru key-value cache
// depends on lkvc_pkg, the lkvc channel interfaces and lru_key_value_cache
module lru_key_value_cache_tb;

   localparam int unsigned ENTRIES    = 16;
   localparam int unsigned KEY_BITS   = 32;
   localparam int unsigned VALUE_BITS = 64;
   localparam int unsigned CAP_BITS   = lkvc_pkg::CAP_BITS;

   typedef struct {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } lookup_result_type;

   logic clock;
   logic reset;

   lkvc_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
   lkvc_rsp_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) rsp_ch ();
   lkvc_csr_if csr_ch ();

   lru_key_value_cache #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   // cache image kept by the bench
   logic                  slot_live [ENTRIES];
   logic [KEY_BITS-1:0]   slot_key  [ENTRIES];
   logic [VALUE_BITS-1:0] slot_value[ENTRIES];
   int unsigned           slot_rank [ENTRIES];
   int unsigned           live_entries;
   logic [CAP_BITS-1:0]   capacity_setting;

   lookup_result_type pending_results[$];
   int unsigned       mismatch_count;
   logic              quiet_phase;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // move a slot to the front; entries that were more recent age by one
   function automatic void promote_slot(int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[s] = 0;
   endfunction

   // free a slot; entries that were less recent move up by one
   function automatic void release_slot(int s);
      int unsigned r;
      r = slot_rank[s];
      slot_live[s] = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && slot_rank[i] > r) slot_rank[i]--;
      end
      slot_rank[s] = 0;
      if (live_entries > 0) live_entries--;
   endfunction

   function automatic lookup_result_type apply_request(lkvc_pkg::op_type op,
                                                       logic [KEY_BITS-1:0] key,
                                                       logic [VALUE_BITS-1:0] value);
      lookup_result_type res;
      int                found;
      int                oldest;
      int                free_slot;
      int unsigned       limit;
      res = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_live[i] && slot_key[i] == key) found = i;
      end
      case (op)
         lkvc_pkg::OP_GET: begin
            if (found >= 0) begin
               res.hit = 1'b1;
               res.read_value = slot_value[found];
               promote_slot(found);
            end
         end
         lkvc_pkg::OP_PUT: begin
            if (found >= 0) begin
               res.hit = 1'b1;
               slot_value[found] = value;
               promote_slot(found);
            end else begin
               limit = (capacity_setting == '0) ? 32'd1 : 32'(capacity_setting);
               if (limit > ENTRIES) limit = ENTRIES;
               if (live_entries >= limit) begin
                  oldest = -1;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (slot_live[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
                        oldest = i;
                  end
                  if (oldest >= 0) begin
                     res.evicted = 1'b1;
                     res.evicted_key = slot_key[oldest];
                     release_slot(oldest);
                  end
               end
               free_slot = -1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (free_slot < 0 && !slot_live[i]) free_slot = i;
               end
               if (free_slot >= 0) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (slot_live[i]) slot_rank[i]++;
                  end
                  slot_live[free_slot] = 1'b1;
                  slot_key[free_slot] = key;
                  slot_value[free_slot] = value;
                  slot_rank[free_slot] = 0;
                  live_entries++;
               end
            end
         end
         lkvc_pkg::OP_DEL: begin
            if (found >= 0) begin
               res.hit = 1'b1;
               release_slot(found);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // response side: random backpressure except in quiet phases
   always @(negedge clock) begin
      rsp_ch.ready <= quiet_phase || ($urandom_range(0, 99) >= 33);
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: hit=%0b read_value=%h evicted=%0b evicted_key=%h",
                        rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.hit !== want.hit || rsp_ch.read_value !== want.read_value ||
                rsp_ch.evicted !== want.evicted || rsp_ch.evicted_key !== want.evicted_key) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch at %0t: expected hit=%0b read_value=%h",
                           $realtime, want.hit, want.read_value);
                  $display("   expected evicted=%0b evicted_key=%h",
                           want.evicted, want.evicted_key);
                  $display("   actual   hit=%0b read_value=%h evicted=%0b evicted_key=%h",
                           rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key);
               end
            end
         end
      end
   end

   // leaves valid high so back-to-back items need not drop valid between them
   task automatic send_item(lkvc_pkg::op_type op, logic [KEY_BITS-1:0] key,
                            logic [VALUE_BITS-1:0] value);
      int unsigned gap;
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.key   <= key;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(apply_request(op, key, value));
   endtask

   task automatic drain_cache();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] cap);
      drain_cache();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= cap;
      do @(posedge clock); while (!csr_ch.ready);
      capacity_setting = cap;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_single_ops();
      send_item(lkvc_pkg::OP_GET, 32'd5, '0);
      send_item(lkvc_pkg::OP_PUT, '0, '0);
      send_item(lkvc_pkg::OP_PUT, '1, '1);
      send_item(lkvc_pkg::OP_GET, '1, '0);
      send_item(lkvc_pkg::OP_GET, '0, '1);
      send_item(lkvc_pkg::OP_PUT, '0, 64'h0123_4567_89ab_cdef);
      send_item(lkvc_pkg::OP_NONE, '1, '1);
      send_item(lkvc_pkg::OP_DEL, '1, '1);
      send_item(lkvc_pkg::OP_DEL, '1, '0);
      send_item(lkvc_pkg::OP_GET, '1, '0);
      send_item(lkvc_pkg::OP_GET, '0, '0);
   endtask

   // zero capacity behaves as one: every new key pushes out the previous one
   task automatic test_min_capacity();
      write_capacity(5'd0);
      send_item(lkvc_pkg::OP_PUT, 32'd1, 64'd11);
      send_item(lkvc_pkg::OP_PUT, 32'd2, 64'd22);
      send_item(lkvc_pkg::OP_GET, 32'd1, '0);
      send_item(lkvc_pkg::OP_GET, 32'd2, '0);
   endtask

   // capacity above the pool, then lowered below the live count
   task automatic test_capacity_shrink();
      write_capacity(5'd31);
      for (int k = 10; k < 14; k++) send_item(lkvc_pkg::OP_PUT, 32'(k), {$urandom, $urandom});
      write_capacity(5'd2);
      send_item(lkvc_pkg::OP_PUT, 32'd20, 64'd200);
      send_item(lkvc_pkg::OP_PUT, 32'd21, 64'd210);
      send_item(lkvc_pkg::OP_GET, 32'd12, '0);
   endtask

   task automatic test_random_traffic();
      logic [CAP_BITS-1:0]   cap_choices[5] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2};
      logic [KEY_BITS-1:0]   key_pool[$];
      logic [KEY_BITS-1:0]   key;
      lkvc_pkg::op_type      op;
      int unsigned           pool_size;
      int unsigned           pick;
      for (int phase = 0; phase < 10; phase++) begin
         write_capacity(phase < 5 ? cap_choices[phase] : CAP_BITS'($urandom_range(0, 31)));
         quiet_phase = (phase == 2);
         pool_size = $urandom_range(2, 28);
         key_pool.delete();
         for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
         key_pool.push_back('0);
         key_pool.push_back('1);
         for (int n = 0; n < 110; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) op = lkvc_pkg::OP_GET;
            else if (pick < 80) op = lkvc_pkg::OP_PUT;
            else if (pick < 95) op = lkvc_pkg::OP_DEL;
            else op = lkvc_pkg::OP_NONE;
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_item(op, key, {$urandom, $urandom});
         end
      end
      quiet_phase = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      quiet_phase = 1'b0;
      mismatch_count = 0;
      req_ch.valid = 1'b0;
      req_ch.op    = lkvc_pkg::OP_GET;
      req_ch.key   = '0;
      req_ch.value = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_live[i]  = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_rank[i]  = 0;
      end
      live_entries = 0;
      capacity_setting = lkvc_pkg::CAP_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_ops();
      test_min_capacity();
      test_capacity_shrink();
      test_random_traffic();

      drain_cache();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule
